// ----- sv/fqm_pkg.sv -----
// Package with shared constants and types for the FIFO queue with membership query.
`default_nettype none

package fqm_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        CMD_ENQUEUE  = 2'd0,
        CMD_DEQUEUE  = 2'd1,
        CMD_PEEK     = 2'd2,
        CMD_CONTAINS = 2'd3
    } cmd_t;

endpackage

`default_nettype wire

// ----- sv/fqm_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module fqm_ram #(
    parameter int W = fqm_pkg::WIDTH_DEF,
    parameter int D = fqm_pkg::DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] ram_reg [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/fifo_queue_with_membership.sv -----
// Top level of the FIFO queue with enqueue, dequeue, peek and membership query.
//
//   Channel   Signals                               Role
//   cmd       cmd_valid, cmd_ready, command, data_in    one command transaction in
//   rsp       rsp_valid, rsp_ready, ok, data_out,       one result transaction out
//             found, count
//
// Enqueue, refused commands and a contains query on an empty queue go straight to done;
// dequeue and peek pass the read state, a contains query the scan state, reading the slot RAM one word per cycle.
// Reset clears the pointers and occupancy at once; the slot RAM is not cleared.
// A new command is taken while the previous result still waits in the output register;
// a result is held back only while the output register is full and not taken.
`default_nettype none

module fifo_queue_with_membership #(
    parameter int DEPTH = fqm_pkg::DEPTH_DEF,
    parameter int WIDTH = fqm_pkg::WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  fqm_pkg::cmd_t                  command,
    input  logic [fqm_pkg::DATA_W-1:0]     data_in,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic                           ok,
    output logic [fqm_pkg::DATA_W-1:0]     data_out,
    output logic                           found,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    import fqm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (WIDTH > DATA_W) ? WIDTH : DATA_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    state_t         state_reg, state_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [AW-1:0]  tail_reg, tail_next;
    logic [CW-1:0]  occ_reg, occ_next;
    logic [AW-1:0]  scan_addr_reg, scan_addr_next;
    logic [CW-1:0]  issued_reg, issued_next;
    logic           rsp_valid_reg, rsp_valid_next;

    logic [WIDTH-1:0] word_reg, word_next;
    logic             r_ok_reg, r_ok_next;
    logic [WIDTH-1:0] r_data_reg, r_data_next;
    logic             r_found_reg, r_found_next;
    logic             ok_reg, ok_next;
    logic [WIDTH-1:0] data_reg, data_next;
    logic             found_reg, found_next;
    logic [CW-1:0]    count_reg, count_next;

    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [WIDTH-1:0] ram_rdata;

    logic [XW-1:0]    din_ext;
    logic [WIDTH-1:0] word_in;
    logic [XW-1:0]    dout_ext;

    assign din_ext  = XW'(data_in);
    assign word_in  = din_ext[WIDTH-1:0];
    assign dout_ext = XW'(data_reg);

    fqm_ram #(
        .W (WIDTH),
        .D (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (word_in),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        scan_addr_next = scan_addr_reg;
        issued_next    = issued_reg;
        rsp_valid_next = rsp_valid_reg;
        word_next      = word_reg;
        r_ok_next      = r_ok_reg;
        r_data_next    = r_data_reg;
        r_found_next   = r_found_reg;
        ok_next        = ok_reg;
        data_next      = data_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = tail_reg;
        ram_raddr      = head_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    word_next    = word_in;
                    r_ok_next    = 1'b0;
                    r_data_next  = '0;
                    r_found_next = 1'b0;
                    state_next   = S_DONE;
                    unique case (command)
                        CMD_ENQUEUE:
                        begin
                            if (occ_reg != FULL_CNT)
                            begin
                                ram_we    = 1'b1;
                                tail_next = next_idx(tail_reg);
                                occ_next  = occ_reg + 1'b1;
                                r_ok_next = 1'b1;
                            end
                        end
                        CMD_DEQUEUE, CMD_PEEK:
                        begin
                            if (occ_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                r_ok_next  = 1'b1;
                                state_next = S_READ;
                                if (command == CMD_DEQUEUE)
                                begin
                                    head_next = next_idx(head_reg);
                                    occ_next  = occ_reg - 1'b1;
                                end
                            end
                        end
                        CMD_CONTAINS:
                        begin
                            r_ok_next = 1'b1;
                            if (occ_reg != '0)
                            begin
                                ram_re         = 1'b1;
                                scan_addr_next = next_idx(head_reg);
                                issued_next    = CW'(1);
                                state_next     = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                r_data_next = ram_rdata;
                state_next  = S_DONE;
            end
            S_SCAN:
            begin
                if (ram_rdata == word_reg)
                begin
                    r_found_next = 1'b1;
                end
                if (issued_reg < occ_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = scan_addr_reg;
                    scan_addr_next = next_idx(scan_addr_reg);
                    issued_next    = issued_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ok_next        = r_ok_reg;
                    data_next      = r_data_reg;
                    found_next     = r_found_reg;
                    count_next     = occ_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            scan_addr_reg <= '0;
            issued_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            scan_addr_reg <= scan_addr_next;
            issued_reg    <= issued_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        r_ok_reg    <= r_ok_next;
        r_data_reg  <= r_data_next;
        r_found_reg <= r_found_next;
        ok_reg      <= ok_next;
        data_reg    <= data_next;
        found_reg   <= found_next;
        count_reg   <= count_next;
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign ok        = ok_reg;
    assign data_out  = dout_ext[DATA_W-1:0];
    assign found     = found_reg;
    assign count     = count_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_CNT)
        else $error("Occupancy exceeds the queue depth.");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0 || occ_reg == FULL_CNT) |-> head_reg == tail_reg)
        else $error("Head and tail disagree for an empty or full queue.");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> (issued_reg <= occ_reg && issued_reg != '0))
        else $error("Membership scan read more words than are stored.");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !ok) |-> (data_out == '0 && !found))
        else $error("A refused transaction returned nonzero data or a match.");

    a_contains_path: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && command == CMD_CONTAINS)
        |=> (state_reg == S_SCAN || state_reg == S_DONE))
        else $error("Membership query did not enter the scan or completion state.");

endmodule

`default_nettype wire

// ----- tb/fqm_result_checker.sv -----
// Checker that predicts each queue result from the command transactions and compares it.
module fqm_result_checker #(
    parameter int DEPTH = fqm_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    input  logic                               cmd_ready,
    input  fqm_pkg::cmd_t                      command,
    input  logic [fqm_pkg::DATA_W-1:0]         data_in,
    input  logic                               rsp_valid,
    input  logic                               rsp_ready,
    input  logic                               ok,
    input  logic [fqm_pkg::DATA_W-1:0]         data_out,
    input  logic                               found,
    input  logic [$clog2(DEPTH+1)-1:0]         count,
    output int                                 fail_count,
    output int                                 pending
);
    import fqm_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] data_out;
        logic              found;
        logic [CW-1:0]     count;
    } queue_result_t;

    logic [DATA_W-1:0] stored_words [DEPTH];
    int                head_slot = 0;
    int                tail_slot = 0;
    int                held_words = 0;
    queue_result_t     awaited_results [$];
    queue_result_t     expected;
    int                mismatches = 0;
    int                waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    function automatic int next_slot(input int slot);
        return (slot + 1 >= DEPTH) ? 0 : slot + 1;
    endfunction

    function automatic queue_result_t apply_command(input cmd_t c, input logic [DATA_W-1:0] word);
        queue_result_t r;
        int            slot;
        r = '0;
        case (c)
            CMD_ENQUEUE:
            begin
                if (held_words < DEPTH)
                begin
                    stored_words[tail_slot] = word;
                    tail_slot = next_slot(tail_slot);
                    held_words++;
                    r.ok = 1'b1;
                end
            end
            CMD_DEQUEUE, CMD_PEEK:
            begin
                if (held_words > 0)
                begin
                    r.data_out = stored_words[head_slot];
                    r.ok = 1'b1;
                    if (c == CMD_DEQUEUE)
                    begin
                        head_slot = next_slot(head_slot);
                        held_words--;
                    end
                end
            end
            default:
            begin
                slot = head_slot;
                for (int k = 0; k < held_words; k++)
                begin
                    if (stored_words[slot] == word)
                        r.found = 1'b1;
                    slot = next_slot(slot);
                end
                r.ok = 1'b1;
            end
        endcase
        r.count = CW'(held_words);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_slot = 0;
            tail_slot = 0;
            held_words = 0;
            awaited_results.delete();
            waiting = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("Result transaction arrived with no command waiting for it.");
                    mismatches++;
                end
                else
                begin
                    expected = awaited_results.pop_front();
                    check_field("ok", DATA_W'(expected.ok), DATA_W'(ok));
                    check_field("data_out", expected.data_out, data_out);
                    check_field("found", DATA_W'(expected.found), DATA_W'(found));
                    check_field("count", DATA_W'(expected.count), DATA_W'(count));
                end
            end
            if (cmd_valid && cmd_ready)
                awaited_results.push_back(apply_command(command, data_in));
            waiting = awaited_results.size();
        end
    end

endmodule

// ----- tb/tb_fifo_queue_with_membership.sv -----
// Testbench top that drives command transactions, takes results and gives the verdict.
module tb_fifo_queue_with_membership;
    import fqm_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int CW           = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 1150;
    localparam int LONG_HOLD    = 120;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int POOL_SIZE    = 6;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } load_mode_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_ready;
    cmd_t              command   = CMD_ENQUEUE;
    logic [DATA_W-1:0] data_in   = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    logic              ok;
    logic [DATA_W-1:0] data_out;
    logic              found;
    logic [CW-1:0]     count;
    int                fail_count;
    int                pending;

    bit                tx_idle_on  = 1'b1;
    bit                rx_idle_on  = 1'b1;
    bit                rx_hold_req = 1'b0;
    int                quiet_cycles = 0;
    logic [DATA_W-1:0] word_pool [POOL_SIZE];

    always #10 clk = ~clk;

    fifo_queue_with_membership #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH_DEF)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .command   (command),
        .data_in   (data_in),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ok        (ok),
        .data_out  (data_out),
        .found     (found),
        .count     (count)
    );

    fqm_result_checker #(
        .DEPTH (DEPTH)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .command    (command),
        .data_in    (data_in),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .ok         (ok),
        .data_out   (data_out),
        .found      (found),
        .count      (count),
        .fail_count (fail_count),
        .pending    (pending)
    );

    task automatic push_command(input cmd_t c, input logic [DATA_W-1:0] word);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command   <= c;
        data_in   <= word;
        do @(posedge clk); while (!cmd_ready);
    endtask

    task automatic await_all_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic cmd_t pick_command(input load_mode_t mode);
        int roll;
        int enq_w;
        int deq_w;
        int peek_w;
        case (mode)
            MODE_FILL:
            begin
                enq_w = 60; deq_w = 15; peek_w = 10;
            end
            MODE_DRAIN:
            begin
                enq_w = 15; deq_w = 55; peek_w = 15;
            end
            default:
            begin
                enq_w = 30; deq_w = 30; peek_w = 15;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < enq_w)
            return CMD_ENQUEUE;
        if (roll < enq_w + deq_w)
            return CMD_DEQUEUE;
        if (roll < enq_w + deq_w + peek_w)
            return CMD_PEEK;
        return CMD_CONTAINS;
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return word_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 50)
            return '0;
        if (roll < 55)
            return '1;
        if (roll < 62)
            return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
        return $urandom;
    endfunction

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            stall = rx_idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    initial
    begin
        int         sent;
        int         burst;
        int         burst_len;
        load_mode_t mode;
        for (int i = 0; i < POOL_SIZE; i++)
            word_pool[i] = $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The queue starts empty, is filled to the brim, refuses one more and is probed.
        push_command(CMD_DEQUEUE, '1);
        push_command(CMD_PEEK, '0);
        push_command(CMD_CONTAINS, '1);
        for (int k = 0; k < DEPTH; k++)
        begin
            if (k == 0)
                push_command(CMD_ENQUEUE, '0);
            else if (k == 1)
                push_command(CMD_ENQUEUE, '1);
            else
                push_command(CMD_ENQUEUE, (k % 2 == 0) ? word_pool[k % POOL_SIZE] : $urandom);
        end
        push_command(CMD_ENQUEUE, 32'hA5A5_5A5A);
        push_command(CMD_CONTAINS, word_pool[(DEPTH - 2) % POOL_SIZE]);
        push_command(CMD_PEEK, 32'h1234_5678);
        push_command(CMD_DEQUEUE, '1);
        push_command(CMD_CONTAINS, '0);

        sent = 0;
        burst = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode = load_mode_t'($urandom_range(0, 2));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
                word_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
            if (burst == 3 || burst == 20)
            begin
                rx_hold_req = 1'b1;
                mode = MODE_FILL;
                tx_idle_on = 1'b0;
            end
            burst_len = $urandom_range(20, 60);
            repeat (burst_len)
            begin
                push_command(pick_command(mode), pick_word());
                sent++;
            end
            if (burst % 4 == 2)
                await_all_results();
            burst++;
        end

        await_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
